// File: design/rpd_pkg.sv
// Shared types and constants for the room presence detector.
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

  // Operation codes carried by an input beat
  localparam logic [1:0] OP_SENSOR = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LIGHT_ON_LEVEL   = 3'd0;
  localparam logic [2:0] CFG_LIGHT_JUMP       = 3'd1;
  localparam logic [2:0] CFG_NEAR_RSSI        = 3'd2;
  localparam logic [2:0] CFG_ENTRY_RSSI       = 3'd3;
  localparam logic [2:0] CFG_AWAY_TIMEOUT_MS  = 3'd4;
  localparam logic [2:0] CFG_RADIO_HOLDOFF_MS = 3'd5;
  localparam logic [2:0] CFG_LIGHT_HOLDOFF_MS = 3'd6;
  localparam logic [2:0] CFG_SCAN_PERIOD_MS   = 3'd7;

  // Reset values of the configuration registers
  localparam logic [11:0]       RST_LIGHT_ON_LEVEL   = 12'd800;
  localparam logic [11:0]       RST_LIGHT_JUMP       = 12'd400;
  localparam logic signed [7:0] RST_NEAR_RSSI        = -8'sd65;
  localparam logic signed [7:0] RST_ENTRY_RSSI       = -8'sd60;
  localparam logic [31:0]       RST_AWAY_TIMEOUT_MS  = 32'd180000;
  localparam logic [31:0]       RST_RADIO_HOLDOFF_MS = 32'd30000;
  localparam logic [31:0]       RST_LIGHT_HOLDOFF_MS = 32'd15000;
  localparam logic [31:0]       RST_SCAN_PERIOD_MS   = 32'd10000;

  // Signal strength floor, used at reset and after each scan epoch
  localparam logic signed [7:0] RSSI_FLOOR = -8'sd120;

  // Last entry cause
  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_RADIO = 2'd1,
    CAUSE_LIGHT = 2'd2
  } cause_e;

  // Configuration register file contents
  typedef struct packed {
    logic [11:0]       light_on_level;
    logic [11:0]       light_jump;
    logic signed [7:0] near_rssi;
    logic signed [7:0] entry_rssi;
    logic [31:0]       away_timeout_ms;
    logic [31:0]       radio_holdoff_ms;
    logic [31:0]       light_holdoff_ms;
    logic [31:0]       scan_period_ms;
  } cfg_t;

  // Classified beat passed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       now_ms;
    logic              night;
    logic              switch_on;
    logic signed [7:0] rssi;
  } qitem_t;

endpackage

`default_nettype wire

// File: design/room_presence_detector.sv
// Top level of the room presence detector: config registers, front, queue, back.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------------
//   in       | input     | in_valid_i/in_ready_o  | operation, now_ms, light_level,
//            |           |                        | night_mode, rssi
//   out      | output    | out_valid_o/out_ready_i| in_room, presence_flag,
//            |           |                        | strongest_rssi, trigger_cause, entered
//   cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while out_ready_i is high; a beat's result passes two
// registers (front classify into the queue at the accepting edge, back state update into
// the result register when the back end pops the queue entry).
// The back end's state update at each pop sets the rate of one beat per cycle.
// Reset clears control state and loads the default configuration; no clearing pass.
// A stalled output holds the back end; the queue keeps the front accepting until full.
`timescale 1ns / 1ps
`default_nettype none

module room_presence_detector #(
  parameter int QueueDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [11:0]       light_level_i,
  input  wire logic              night_mode_i,
  input  wire logic signed [7:0] rssi_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   in_room_o,
  output logic                   presence_flag_o,
  output logic signed [7:0]      strongest_rssi_o,
  output logic [1:0]             trigger_cause_o,
  output logic                   entered_o
);
  import rpd_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  qitem_t push_item, pop_item;

  // Configuration write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIGHT_ON_LEVEL:   cfg_d.light_on_level   = cfg_data_i[11:0];
        CFG_LIGHT_JUMP:       cfg_d.light_jump       = cfg_data_i[11:0];
        CFG_NEAR_RSSI:        cfg_d.near_rssi        = cfg_data_i[7:0];
        CFG_ENTRY_RSSI:       cfg_d.entry_rssi       = cfg_data_i[7:0];
        CFG_AWAY_TIMEOUT_MS:  cfg_d.away_timeout_ms  = cfg_data_i;
        CFG_RADIO_HOLDOFF_MS: cfg_d.radio_holdoff_ms = cfg_data_i;
        CFG_LIGHT_HOLDOFF_MS: cfg_d.light_holdoff_ms = cfg_data_i;
        CFG_SCAN_PERIOD_MS:   cfg_d.scan_period_ms   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_on_level   <= RST_LIGHT_ON_LEVEL;
      cfg_q.light_jump       <= RST_LIGHT_JUMP;
      cfg_q.near_rssi        <= RST_NEAR_RSSI;
      cfg_q.entry_rssi       <= RST_ENTRY_RSSI;
      cfg_q.away_timeout_ms  <= RST_AWAY_TIMEOUT_MS;
      cfg_q.radio_holdoff_ms <= RST_RADIO_HOLDOFF_MS;
      cfg_q.light_holdoff_ms <= RST_LIGHT_HOLDOFF_MS;
      cfg_q.scan_period_ms   <= RST_SCAN_PERIOD_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .now_ms_i      (now_ms_i),
    .light_level_i (light_level_i),
    .night_mode_i  (night_mode_i),
    .rssi_i        (rssi_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  rpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  rpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_item_i       (pop_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .in_room_o        (in_room_o),
    .presence_flag_o  (presence_flag_o),
    .strongest_rssi_o (strongest_rssi_o),
    .trigger_cause_o  (trigger_cause_o),
    .entered_o        (entered_o)
  );

endmodule

`default_nettype wire

// File: design/rpd_front.sv
// Front end: accepts input beats, detects light-on events, pushes classified beats.
`timescale 1ns / 1ps
`default_nettype none

module rpd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rpd_pkg::cfg_t         cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic [31:0]           now_ms_i,
  input  wire logic [11:0]           light_level_i,
  input  wire logic                  night_mode_i,
  input  wire logic signed [7:0]     rssi_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output rpd_pkg::qitem_t            push_item_o
);
  import rpd_pkg::*;

  logic        was_night_q, was_night_d;
  logic [11:0] prev_light_q, prev_light_d;
  logic        night_fell, level_cross, level_jump, switch_on;
  logic [12:0] jump_target;
  logic        accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // Light-on detection against the previous sensor sample
  always_comb begin
    jump_target = {1'b0, prev_light_q} + {1'b0, cfg_i.light_jump};
    night_fell  = was_night_q && !night_mode_i;
    level_cross = (prev_light_q != 12'd0) && (light_level_i >= cfg_i.light_on_level) &&
                  (prev_light_q < cfg_i.light_on_level);
    level_jump  = (prev_light_q != 12'd0) && ({1'b0, light_level_i} >= jump_target) &&
                  (light_level_i >= cfg_i.light_on_level);
    switch_on   = night_fell || level_cross || level_jump;
  end

  // Classified beat
  always_comb begin
    push_item_o.op        = operation_i;
    push_item_o.now_ms    = now_ms_i;
    push_item_o.night     = night_mode_i;
    push_item_o.switch_on = switch_on;
    push_item_o.rssi      = rssi_i;
  end

  // Sample history moves only on accepted sensor updates
  always_comb begin
    was_night_d  = was_night_q;
    prev_light_d = prev_light_q;
    if (accept && (operation_i == OP_SENSOR)) begin
      was_night_d  = night_mode_i;
      prev_light_d = light_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_night_q  <= 1'b0;
      prev_light_q <= 12'd0;
    end else begin
      was_night_q  <= was_night_d;
      prev_light_q <= prev_light_d;
    end
  end

endmodule

`default_nettype wire

// File: design/rpd_queue.sv
// Short FIFO of classified beats between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module rpd_queue #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire rpd_pkg::qitem_t push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output rpd_pkg::qitem_t      pop_item_o
);
  import rpd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qitem_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue fill count beyond depth");

  a_push_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: design/rpd_back.sv
// Back end: room state machine, scan epochs and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rpd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpd_pkg::cfg_t     cfg_i,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  input  wire rpd_pkg::qitem_t   pop_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   in_room_o,
  output logic                   presence_flag_o,
  output logic signed [7:0]      strongest_rssi_o,
  output logic [1:0]             trigger_cause_o,
  output logic                   entered_o
);
  import rpd_pkg::*;

  // Room state, local to this machine
  typedef enum logic {
    ST_AWAY    = 1'b0,
    ST_IN_ROOM = 1'b1
  } room_e;

  room_e             room_q, room_d;
  logic [31:0]       last_scan_q, last_scan_d;
  logic [31:0]       last_strong_q, last_strong_d;
  logic [31:0]       last_trigger_q, last_trigger_d;
  logic signed [7:0] strongest_q, strongest_d;
  logic signed [7:0] scan_max_q, scan_max_d;
  logic              sticky_q, sticky_d;
  cause_e            cause_q, cause_d;
  logic              entered_d;

  logic              out_valid_q, out_valid_d;
  logic              out_room_q, out_sticky_q, out_entered_q;
  logic signed [7:0] out_strong_q;
  cause_e            out_cause_q;

  logic              do_pop;
  logic [31:0]       since_scan, since_strong, since_trigger;
  logic              scan_due, scan_strong, radio_ok, light_ok;
  logic signed [7:0] rssi_in;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign rssi_in     = pop_item_i.rssi;

  // Elapsed times, all modulo 2^32
  always_comb begin
    since_scan    = pop_item_i.now_ms - last_scan_q;
    since_strong  = pop_item_i.now_ms - last_strong_q;
    since_trigger = pop_item_i.now_ms - last_trigger_q;
    scan_due      = since_scan >= cfg_i.scan_period_ms;
    scan_strong   = scan_due && (scan_max_q >= cfg_i.near_rssi);
  end

  // Next state for one beat
  always_comb begin
    room_d         = room_q;
    last_scan_d    = last_scan_q;
    last_strong_d  = last_strong_q;
    last_trigger_d = last_trigger_q;
    strongest_d    = strongest_q;
    scan_max_d     = scan_max_q;
    sticky_d       = sticky_q;
    cause_d        = cause_q;
    entered_d      = 1'b0;
    radio_ok       = 1'b0;
    light_ok       = 1'b0;
    case (pop_item_i.op)
      OP_SENSOR: begin
        if (scan_due) begin
          last_scan_d = pop_item_i.now_ms;
          strongest_d = scan_max_q;
          scan_max_d  = RSSI_FLOOR;
        end
        if (scan_strong) last_strong_d = pop_item_i.now_ms;
        radio_ok = (strongest_d >= cfg_i.entry_rssi) &&
                   (since_trigger >= cfg_i.radio_holdoff_ms);
        light_ok = pop_item_i.switch_on && (since_trigger >= cfg_i.light_holdoff_ms);
        if (room_q == ST_IN_ROOM) begin
          // a fresh strong epoch makes the elapsed time zero
          if (!scan_strong && (since_strong > cfg_i.away_timeout_ms) && pop_item_i.night)
            room_d = ST_AWAY;
        end else if (radio_ok || light_ok) begin
          room_d         = ST_IN_ROOM;
          sticky_d       = 1'b1;
          last_trigger_d = pop_item_i.now_ms;
          entered_d      = 1'b1;
          if (radio_ok) begin
            cause_d       = CAUSE_RADIO;
            last_strong_d = pop_item_i.now_ms;
          end else begin
            cause_d = CAUSE_LIGHT;
          end
        end
      end
      OP_REPORT: begin
        if (rssi_in > scan_max_q) scan_max_d = rssi_in;
      end
      OP_CLEAR: begin
        sticky_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (do_pop)      out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q         <= ST_AWAY;
      last_scan_q    <= 32'd0;
      last_strong_q  <= 32'd0;
      last_trigger_q <= 32'd0;
      strongest_q    <= RSSI_FLOOR;
      scan_max_q     <= RSSI_FLOOR;
      sticky_q       <= 1'b0;
      cause_q        <= CAUSE_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (do_pop) begin
        room_q         <= room_d;
        last_scan_q    <= last_scan_d;
        last_strong_q  <= last_strong_d;
        last_trigger_q <= last_trigger_d;
        strongest_q    <= strongest_d;
        scan_max_q     <= scan_max_d;
        sticky_q       <= sticky_d;
        cause_q        <= cause_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      out_room_q    <= (room_d == ST_IN_ROOM);
      out_sticky_q  <= sticky_d;
      out_strong_q  <= strongest_d;
      out_cause_q   <= cause_d;
      out_entered_q <= entered_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign in_room_o        = out_room_q;
  assign presence_flag_o  = out_sticky_q;
  assign strongest_rssi_o = out_strong_q;
  assign trigger_cause_o  = out_cause_q;
  assign entered_o        = out_entered_q;

  a_entered_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_entered_q) |->
      (out_room_q && out_sticky_q && (out_cause_q != CAUSE_NONE)))
    else $error("entry beat without room, flag or cause");

  a_entry_from_away: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && entered_d) |-> (room_q == ST_AWAY))
    else $error("entry taken while already in room");

  a_sticky_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q |-> (cause_q != CAUSE_NONE))
    else $error("presence flag set with no cause");

endmodule

`default_nettype wire
